/* design/c2s_pkg.sv */
// shared constants and the arctangent table of the cartesian to spherical converter
package c2s_pkg;

    // fractional bits carried below the input length unit
    localparam int GUARD_BITS = 8;
    // extra integer bits that absorb the vector growth of both rotation chains
    localparam int HEADROOM_BITS = 3;
    // internal angle resolution, 2^31 is pi
    localparam int ANGLE_BITS = 32;
    // widest datapath the gain multiplier split supports
    localparam int MAX_DATA_BITS = 64;

    localparam logic [ANGLE_BITS-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic signed [ANGLE_BITS-1:0] QUARTER_TURN = 32'sd1073741824;
    localparam logic signed [ANGLE_BITS-1:0] NEG_QUARTER_TURN = -32'sd1073741824;

    // round(2^32 / K), K the limit of the rotation gain
    localparam logic [31:0] INV_GAIN = 32'd2608131496;

    localparam int ATAN_ENTRIES = 32;

    // round(atan(2^-i) * 2^31 / pi)
    localparam logic [ANGLE_BITS-1:0] ATAN_ROM [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // micro-rotation angle of one stage, zero past the end of the table
    function automatic logic [ANGLE_BITS-1:0] atan_step(input int unsigned idx);
        logic [ANGLE_BITS-1:0] step;
        step = '0;
        if (idx < ATAN_ENTRIES)
        begin
            step = ATAN_ROM[idx[4:0]];
        end
        return step;
    endfunction

endpackage

/* design/c2s_if.sv */
// valid/ready channels for the position beat and the spherical result beat

interface c2s_pos_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface c2s_sph_if #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] latitude;
    logic signed [ANGLE_WIDTH-1:0] longitude;
    logic        [COORD_WIDTH-1:0] radius;

    modport source (output valid, output latitude, output longitude, output radius,
                    input ready);
    modport sink   (input valid, input latitude, input longitude, input radius,
                    output ready);
endinterface

/* design/c2s_cordic_cell.sv */
// one vectoring micro-rotation stage with its angle accumulator and side payload
module c2s_cordic_cell
    import c2s_pkg::*;
#(
    parameter int              XW         = 43,
    parameter int              SW         = 33,
    parameter int              SHIFT      = 0,
    parameter logic [31:0]     ANGLE_STEP = 32'd0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [XW-1:0]   in_x,
    input  logic signed [XW-1:0]   in_y,
    input  logic [ANGLE_BITS-1:0]  in_angle,
    input  logic [SW-1:0]          in_side,
    output logic                   out_valid,
    output logic signed [XW-1:0]   out_x,
    output logic signed [XW-1:0]   out_y,
    output logic [ANGLE_BITS-1:0]  out_angle,
    output logic [SW-1:0]          out_side
);

    logic                  valid_reg;
    logic signed [XW-1:0]  x_reg;
    logic signed [XW-1:0]  y_reg;
    logic [ANGLE_BITS-1:0] angle_reg;
    logic [SW-1:0]         side_reg;

    logic signed [XW-1:0]  dx;
    logic signed [XW-1:0]  dy;
    logic signed [XW-1:0]  x_next;
    logic signed [XW-1:0]  y_next;
    logic [ANGLE_BITS-1:0] angle_next;

    // rotate toward the positive x axis, direction from the sign of y
    always_comb
    begin
        dx = in_y >>> SHIFT;
        dy = in_x >>> SHIFT;
        if (in_y[XW-1])
        begin
            x_next     = in_x - dx;
            y_next     = in_y + dy;
            angle_next = in_angle - ANGLE_STEP;
        end
        else
        begin
            x_next     = in_x + dx;
            y_next     = in_y - dy;
            angle_next = in_angle + ANGLE_STEP;
        end
    end

    // beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            angle_reg <= angle_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_angle = angle_reg;
    assign out_side  = side_reg;

endmodule

/* design/c2s_gain.sv */
// two-stage gain compensation: magnitude times round(2^32/K), rounded half up
module c2s_gain
    import c2s_pkg::*;
#(
    parameter int XW = 43,
    parameter int SW = 65
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [XW-1:0] in_mag,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [XW-1:0] out_mag,
    output logic [SW-1:0] out_side
);

    localparam int PW = 2 * 32;
    localparam logic [PW:0] ROUND_HALF = (PW+1)'(64'h8000_0000);

    logic [MAX_DATA_BITS-1:0] mag_wide;
    logic [PW-1:0]            lo_prod_next;
    logic [PW-1:0]            hi_prod_next;
    logic [PW:0]              lo_round;
    logic [PW:0]              mag_sum;

    logic                     p1_valid_reg;
    logic [PW-1:0]            lo_prod_reg;
    logic [PW-1:0]            hi_prod_reg;
    logic [SW-1:0]            p1_side_reg;
    logic                     p2_valid_reg;
    logic [XW-1:0]            mag_reg;
    logic [SW-1:0]            p2_side_reg;

    // split the magnitude into two 32-bit halves, one multiplier each
    always_comb
    begin
        mag_wide     = MAX_DATA_BITS'(in_mag);
        lo_prod_next = PW'(mag_wide[31:0]) * PW'(INV_GAIN);
        hi_prod_next = PW'(mag_wide[63:32]) * PW'(INV_GAIN);
    end

    // recombine, rounding only the low partial product
    always_comb
    begin
        lo_round = (PW+1)'(lo_prod_reg) + ROUND_HALF;
        mag_sum  = (PW+1)'(hi_prod_reg) + (PW+1)'(lo_round[PW:32]);
    end

    // beat valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_prod_reg <= lo_prod_next;
            hi_prod_reg <= hi_prod_next;
            p1_side_reg <= in_side;
            mag_reg     <= mag_sum[XW-1:0];
            p2_side_reg <= p1_side_reg;
        end
    end

    assign out_valid = p2_valid_reg;
    assign out_mag   = mag_reg;
    assign out_side  = p2_side_reg;

endmodule

/* design/cartesian_to_spherical.sv */
// Cartesian to spherical converter: longitude, latitude and radius of a position.
// A position beat goes through an input register, a chain of CORDIC_STAGES vectoring
// cells that turns (x, y) onto the x axis, a two-stage gain multiplier, a second chain
// of CORDIC_STAGES cells on (h, z), a second gain multiplier and a rounding stage; the
// result lands in an output register backed by a one-beat skid register. Every stage
// is a register, so one position is taken each clock while the skid register is
// empty. Angles are binary, 2^(ANGLE_WIDTH-1) is pi; the radius is rounded to the
// input unit and saturates. The block has no state beyond its pipeline.
module cartesian_to_spherical
    import c2s_pkg::*;
#(
    parameter int COORD_WIDTH   = 32,
    parameter int ANGLE_WIDTH   = 32,
    parameter int CORDIC_STAGES = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    c2s_pos_if.sink         pos,
    c2s_sph_if.source       sph
);

    localparam int XW  = COORD_WIDTH + GUARD_BITS + HEADROOM_BITS;
    localparam int SW1 = COORD_WIDTH + 1;
    localparam int SWG1 = SW1 + ANGLE_BITS;
    localparam int SW2 = ANGLE_BITS + 1;
    localparam int SWG2 = SW2 + ANGLE_BITS;
    localparam int ANG_SHIFT = 48 - ANGLE_WIDTH;
    localparam logic [63:0] ANG_RND = (ANG_SHIFT > 0) ? (64'd1 << (ANG_SHIFT - 1)) : 64'd0;
    localparam logic [XW:0] RAD_RND = (XW+1)'(2 ** (GUARD_BITS - 1));

    // rescale a 32-bit binary angle to the output width, half-up rounding
    function automatic logic [ANGLE_WIDTH-1:0] angle_scale(input logic signed [31:0] sa);
        logic signed [63:0] wide;
        wide = (64'(sa) <<< 16) + signed'(ANG_RND);
        wide = wide >>> ANG_SHIFT;
        return wide[ANGLE_WIDTH-1:0];
    endfunction

    logic en;

    // input prep: scale, pre-rotate by pi for negative x
    logic                  prep_valid_reg;
    logic signed [XW-1:0]  prep_x_reg;
    logic signed [XW-1:0]  prep_y_reg;
    logic [ANGLE_BITS-1:0] prep_a_reg;
    logic [SW1-1:0]        prep_side_reg;
    logic signed [XW-1:0]  prep_x_next;
    logic signed [XW-1:0]  prep_y_next;
    logic [ANGLE_BITS-1:0] prep_a_next;
    logic signed [XW-1:0]  x_scaled;
    logic signed [XW-1:0]  y_scaled;
    logic                  xy_zero;

    always_comb
    begin
        x_scaled = XW'(pos.pos_x) <<< GUARD_BITS;
        y_scaled = XW'(pos.pos_y) <<< GUARD_BITS;
        xy_zero  = (pos.pos_x == '0) && (pos.pos_y == '0);
        if (pos.pos_x[COORD_WIDTH-1])
        begin
            prep_x_next = -x_scaled;
            prep_y_next = -y_scaled;
            prep_a_next = HALF_TURN;
        end
        else
        begin
            prep_x_next = x_scaled;
            prep_y_next = y_scaled;
            prep_a_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= pos.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_x_reg    <= prep_x_next;
            prep_y_reg    <= prep_y_next;
            prep_a_reg    <= prep_a_next;
            prep_side_reg <= {pos.pos_z, xy_zero};
        end
    end

    // first chain: (x, y) -> longitude and horizontal length
    logic                  c1_valid [0:CORDIC_STAGES];
    logic signed [XW-1:0]  c1_x     [0:CORDIC_STAGES];
    logic signed [XW-1:0]  c1_y     [0:CORDIC_STAGES];
    logic [ANGLE_BITS-1:0] c1_a     [0:CORDIC_STAGES];
    logic [SW1-1:0]        c1_side  [0:CORDIC_STAGES];

    assign c1_valid[0] = prep_valid_reg;
    assign c1_x[0]     = prep_x_reg;
    assign c1_y[0]     = prep_y_reg;
    assign c1_a[0]     = prep_a_reg;
    assign c1_side[0]  = prep_side_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_chain1
        c2s_cordic_cell #(
            .XW         (XW),
            .SW         (SW1),
            .SHIFT      (i),
            .ANGLE_STEP (atan_step(i))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (c1_valid[i]),
            .in_x      (c1_x[i]),
            .in_y      (c1_y[i]),
            .in_angle  (c1_a[i]),
            .in_side   (c1_side[i]),
            .out_valid (c1_valid[i+1]),
            .out_x     (c1_x[i+1]),
            .out_y     (c1_y[i+1]),
            .out_angle (c1_a[i+1]),
            .out_side  (c1_side[i+1])
        );
    end

    // horizontal length
    logic            g1_valid;
    logic [XW-1:0]   g1_mag;
    logic [SWG1-1:0] g1_side;

    c2s_gain #(
        .XW (XW),
        .SW (SWG1)
    ) u_gain_h (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c1_valid[CORDIC_STAGES]),
        .in_mag    (c1_x[CORDIC_STAGES]),
        .in_side   ({c1_side[CORDIC_STAGES], c1_a[CORDIC_STAGES]}),
        .out_valid (g1_valid),
        .out_mag   (g1_mag),
        .out_side  (g1_side)
    );

    // second chain setup: force longitude in the plane origin, flag the full origin
    logic [ANGLE_BITS-1:0]  lon_fixed;
    logic                   g1_xy_zero;
    logic [COORD_WIDTH-1:0] g1_z;
    logic                   origin;

    always_comb
    begin
        g1_xy_zero = g1_side[ANGLE_BITS];
        g1_z       = g1_side[SWG1-1:ANGLE_BITS+1];
        lon_fixed  = g1_xy_zero ? '0 : g1_side[ANGLE_BITS-1:0];
        origin     = (g1_mag == '0) && (g1_z == '0);
    end

    logic                  c2_valid [0:CORDIC_STAGES];
    logic signed [XW-1:0]  c2_x     [0:CORDIC_STAGES];
    logic signed [XW-1:0]  c2_y     [0:CORDIC_STAGES];
    logic [ANGLE_BITS-1:0] c2_a     [0:CORDIC_STAGES];
    logic [SW2-1:0]        c2_side  [0:CORDIC_STAGES];

    assign c2_valid[0] = g1_valid;
    assign c2_x[0]     = signed'(g1_mag);
    assign c2_y[0]     = XW'(signed'(g1_z)) <<< GUARD_BITS;
    assign c2_a[0]     = '0;
    assign c2_side[0]  = {origin, lon_fixed};

    // second chain: (h, z) -> latitude and radius
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_chain2
        c2s_cordic_cell #(
            .XW         (XW),
            .SW         (SW2),
            .SHIFT      (i),
            .ANGLE_STEP (atan_step(i))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (c2_valid[i]),
            .in_x      (c2_x[i]),
            .in_y      (c2_y[i]),
            .in_angle  (c2_a[i]),
            .in_side   (c2_side[i]),
            .out_valid (c2_valid[i+1]),
            .out_x     (c2_x[i+1]),
            .out_y     (c2_y[i+1]),
            .out_angle (c2_a[i+1]),
            .out_side  (c2_side[i+1])
        );
    end

    // radius before rounding
    logic            g2_valid;
    logic [XW-1:0]   g2_mag;
    logic [SWG2-1:0] g2_side;

    c2s_gain #(
        .XW (XW),
        .SW (SWG2)
    ) u_gain_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c2_valid[CORDIC_STAGES]),
        .in_mag    (c2_x[CORDIC_STAGES]),
        .in_side   ({c2_side[CORDIC_STAGES], c2_a[CORDIC_STAGES]}),
        .out_valid (g2_valid),
        .out_mag   (g2_mag),
        .out_side  (g2_side)
    );

    // finish: clamp latitude, origin override, rescale angles, round radius
    logic signed [ANGLE_BITS-1:0] lat_raw;
    logic signed [ANGLE_BITS-1:0] lat_clamped;
    logic                         g2_origin;
    logic [XW:0]                  rad_sum;
    logic [COORD_WIDTH-1:0]       rad_next;
    logic [ANGLE_WIDTH-1:0]       lat_next;
    logic [ANGLE_WIDTH-1:0]       lon_next;

    always_comb
    begin
        lat_raw   = signed'(g2_side[ANGLE_BITS-1:0]);
        g2_origin = g2_side[SWG2-1];
        if (lat_raw > QUARTER_TURN)
        begin
            lat_clamped = QUARTER_TURN;
        end
        else if (lat_raw < NEG_QUARTER_TURN)
        begin
            lat_clamped = NEG_QUARTER_TURN;
        end
        else
        begin
            lat_clamped = lat_raw;
        end
        rad_sum = (XW+1)'(g2_mag) + RAD_RND;
        if (|rad_sum[XW:GUARD_BITS+COORD_WIDTH])
        begin
            rad_next = '1;
        end
        else
        begin
            rad_next = rad_sum[GUARD_BITS+COORD_WIDTH-1:GUARD_BITS];
        end
        lat_next = angle_scale(lat_clamped);
        lon_next = angle_scale(signed'(g2_side[2*ANGLE_BITS-1:ANGLE_BITS]));
        if (g2_origin)
        begin
            lat_next = '0;
            rad_next = '0;
        end
    end

    logic                   fin_valid_reg;
    logic [ANGLE_WIDTH-1:0] fin_lat_reg;
    logic [ANGLE_WIDTH-1:0] fin_lon_reg;
    logic [COORD_WIDTH-1:0] fin_rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_valid_reg <= g2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_lat_reg <= lat_next;
            fin_lon_reg <= lon_next;
            fin_rad_reg <= rad_next;
        end
    end

    // output register with a one-beat skid; the pipeline holds only while the skid is full
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [ANGLE_WIDTH-1:0] out_lat_reg;
    logic [ANGLE_WIDTH-1:0] out_lon_reg;
    logic [COORD_WIDTH-1:0] out_rad_reg;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    logic [ANGLE_WIDTH-1:0] skid_lat_reg;
    logic [ANGLE_WIDTH-1:0] skid_lon_reg;
    logic [COORD_WIDTH-1:0] skid_rad_reg;
    logic                   out_free;
    logic                   load_out;
    logic                   load_skid;

    assign en = !skid_valid_reg;

    always_comb
    begin
        out_free        = !out_valid_reg || sph.ready;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            load_out = 1'b1;
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = fin_valid_reg;
            end
        end
        else if (en && fin_valid_reg)
        begin
            load_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_lat_reg <= skid_lat_reg;
                out_lon_reg <= skid_lon_reg;
                out_rad_reg <= skid_rad_reg;
            end
            else
            begin
                out_lat_reg <= fin_lat_reg;
                out_lon_reg <= fin_lon_reg;
                out_rad_reg <= fin_rad_reg;
            end
        end
        if (load_skid)
        begin
            skid_lat_reg <= fin_lat_reg;
            skid_lon_reg <= fin_lon_reg;
            skid_rad_reg <= fin_rad_reg;
        end
    end

    assign pos.ready     = en;
    assign sph.valid     = out_valid_reg;
    assign sph.latitude  = signed'(out_lat_reg);
    assign sph.longitude = signed'(out_lon_reg);
    assign sph.radius    = out_rad_reg;

endmodule
